// ===== rtl/srr_pkg.sv =====
// Package for the sticky round-robin dispatcher.
// Holds payload widths, register reset value and parameter defaults.
// No dependencies; every other file imports it.
`default_nettype none

package srr_pkg;

   // payload widths fixed by the channel format
   localparam int TASK_ID_W = 32;
   localparam int LANE_W    = 4;
   localparam int CSR_W     = 5;

   // worker count after reset
   localparam logic [CSR_W-1:0] WORKER_COUNT_RESET = 5'd1;

   // defaults for the top level parameters
   localparam int MAX_WORKERS_DEF = 16;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int ID_WIDTH_DEF    = 32;

endpackage

`default_nettype wire

// ===== rtl/srr_if.sv =====
// Valid/ready channel interfaces for dispatch requests and responses.
// Depends on srr_pkg for the payload widths.
`default_nettype none

interface srr_req_if import srr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TASK_ID_W-1:0] task_id;

   modport source (output valid, output task_id, input ready);
   modport sink   (input valid, input task_id, output ready);
endinterface

interface srr_rsp_if import srr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LANE_W-1:0] lane;
   logic              was_known;
   logic              table_full;

   modport source (output valid, output lane, output was_known, output table_full,
                   input ready);
   modport sink   (input valid, input lane, input was_known, input table_full,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/sticky_round_robin_dispatch_top.sv =====
// Top level of the sticky round-robin dispatcher: worker count register,
// dispatch sequencer and affinity table memory.
// Depends on srr_pkg, srr_if, srr_table and srr_ctrl.
//
//   channel | direction | payload                        | handshake
//   req     | in        | task_id[31:0]                  | valid / ready
//   rsp     | out       | lane[3:0], was_known, table_full | valid / ready
//   csr     | in        | worker_count[4:0]              | csr_wr_en, no wait
//
// A new key is compared with every recorded key before it gets a lane,
// fill being the number of recorded keys; a hit on entry k ends the scan early.
// The table scan reads one entry per cycle.
// Reset clears the fill count, the token and the response register; the table
// memory needs no clearing since entries at or above the fill count are unused.
// A response waiting on rsp.ready does not block the next request; only the
// finish step of that next request waits for the response slot.
`default_nettype none

module sticky_round_robin_dispatch_top import srr_pkg::*; #(
   parameter int MAX_WORKERS = MAX_WORKERS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   srr_req_if.sink               req,
   srr_rsp_if.source             rsp,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int TOK_W = $clog2(MAX_WORKERS);

   logic [CSR_W-1:0]    worker_count_ff;
   logic                tbl_wr_en;
   logic [AW-1:0]       tbl_wr_addr;
   logic [ID_WIDTH-1:0] tbl_wr_key;
   logic [TOK_W-1:0]    tbl_wr_lane;
   logic [AW-1:0]       tbl_rd_addr;
   logic [ID_WIDTH-1:0] tbl_rd_key;
   logic [TOK_W-1:0]    tbl_rd_lane;

   // hold worker count register
   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff <= WORKER_COUNT_RESET;
      end else if (csr_wr_en) begin
         worker_count_ff <= csr_wr_data;
      end
   end

   srr_ctrl #(
      .MAX_WORKERS (MAX_WORKERS),
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .worker_count (worker_count_ff),
      .req          (req),
      .rsp          (rsp),
      .tbl_wr_en    (tbl_wr_en),
      .tbl_wr_addr  (tbl_wr_addr),
      .tbl_wr_key   (tbl_wr_key),
      .tbl_wr_lane  (tbl_wr_lane),
      .tbl_rd_addr  (tbl_rd_addr),
      .tbl_rd_key   (tbl_rd_key),
      .tbl_rd_lane  (tbl_rd_lane)
   );

   srr_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_WIDTH    (ID_WIDTH),
      .LANE_BITS   (TOK_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_wr_en),
      .wr_addr    (tbl_wr_addr),
      .wr_key     (tbl_wr_key),
      .wr_lane    (tbl_wr_lane),
      .rd_addr    (tbl_rd_addr),
      .rd_key_ff  (tbl_rd_key),
      .rd_lane_ff (tbl_rd_lane)
   );

endmodule

`default_nettype wire

// ===== rtl/srr_table.sv =====
// Affinity table memory: one write port, one read port, registered read data.
// Each entry holds a task key and its assigned lane. Depends on srr_pkg.
`default_nettype none

module srr_table import srr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF,
   parameter int LANE_BITS   = 4
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  wire logic [ID_WIDTH-1:0]            wr_key,
   input  wire logic [LANE_BITS-1:0]           wr_lane,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic      [ID_WIDTH-1:0]            rd_key_ff,
   output logic      [LANE_BITS-1:0]           rd_lane_ff
);

   logic [ID_WIDTH-1:0]  key_mem  [TABLE_DEPTH];
   logic [LANE_BITS-1:0] lane_mem [TABLE_DEPTH];

   // write entry, register read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         lane_mem[wr_addr] <= wr_lane;
      end
      rd_key_ff  <= key_mem[rd_addr];
      rd_lane_ff <= lane_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/srr_ctrl.sv =====
// Dispatch sequencer: scans the affinity table one entry per cycle, assigns
// round-robin lanes to new keys, records them and holds the response.
// Depends on srr_pkg and the channel interfaces in srr_if.
`default_nettype none

module srr_ctrl import srr_pkg::*; #(
   parameter int MAX_WORKERS = MAX_WORKERS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [CSR_W-1:0]                      worker_count,
   srr_req_if.sink                                    req,
   srr_rsp_if.source                                  rsp,
   output logic                                       tbl_wr_en,
   output logic      [$clog2(TABLE_DEPTH)-1:0]        tbl_wr_addr,
   output logic      [ID_WIDTH-1:0]                   tbl_wr_key,
   output logic      [$clog2(MAX_WORKERS)-1:0]        tbl_wr_lane,
   output logic      [$clog2(TABLE_DEPTH)-1:0]        tbl_rd_addr,
   input  wire logic [ID_WIDTH-1:0]                   tbl_rd_key,
   input  wire logic [$clog2(MAX_WORKERS)-1:0]        tbl_rd_lane
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int TOK_W = $clog2(MAX_WORKERS);
   localparam int CNT_W = (TOK_W > CSR_W) ? TOK_W + 1 : CSR_W + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type        state_ff;
   logic [ID_WIDTH-1:0] key_ff;
   logic [AW-1:0]    rd_idx_ff;
   logic             hit_ff;
   logic [TOK_W-1:0] hit_lane_ff;
   logic [AW:0]      fill_ff;
   logic [TOK_W-1:0] token_ff;
   logic             rsp_valid_ff;
   logic [LANE_W-1:0] rsp_lane_ff;
   logic             rsp_known_ff;
   logic             rsp_full_ff;

   logic [CNT_W-1:0] wc_ext;
   logic [CNT_W-1:0] lanes_used;
   logic [CNT_W-1:0] tok_ext;
   logic [CNT_W-1:0] tok_lane;
   logic [CNT_W-1:0] tok_inc;
   logic [TOK_W-1:0] token_in;
   logic             slot_free;
   logic             key_match;
   logic             scan_last;
   logic             table_has_room;

   // clamp worker count to 1..MAX_WORKERS
   always_comb begin
      wc_ext = CNT_W'(worker_count);
      if (wc_ext == '0) begin
         lanes_used = CNT_W'(1);
      end else if (wc_ext > CNT_W'(MAX_WORKERS)) begin
         lanes_used = CNT_W'(MAX_WORKERS);
      end else begin
         lanes_used = wc_ext;
      end
   end

   // pick lane from token, advance and wrap
   always_comb begin
      tok_ext  = CNT_W'(token_ff);
      tok_lane = (tok_ext >= lanes_used) ? '0 : tok_ext;
      tok_inc  = tok_lane + CNT_W'(1);
      token_in = (tok_inc >= lanes_used) ? '0 : TOK_W'(tok_inc);
   end

   assign slot_free      = !rsp_valid_ff || rsp.ready;
   assign key_match      = (tbl_rd_key == key_ff);
   assign scan_last      = ((AW + 1)'(rd_idx_ff) + (AW + 1)'(1)) == fill_ff;
   assign table_has_room = fill_ff < (AW + 1)'(TABLE_DEPTH);

   // table access: read ahead during scan, record new key on finish
   assign tbl_rd_addr = (state_ff == ST_SCAN) ? rd_idx_ff + AW'(1) : '0;
   assign tbl_wr_en   = (state_ff == ST_FINISH) && slot_free && !hit_ff && table_has_room;
   assign tbl_wr_addr = fill_ff[AW-1:0];
   assign tbl_wr_key  = key_ff;
   assign tbl_wr_lane = TOK_W'(tok_lane);

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.lane       = rsp_lane_ff;
   assign rsp.was_known  = rsp_known_ff;
   assign rsp.table_full = rsp_full_ff;

   // sequencer state, token, fill count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         token_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         // load a new response on finish, else drop the one taken
         if ((state_ff == ST_FINISH) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  key_ff    <= ID_WIDTH'(req.task_id);
                  rd_idx_ff <= '0;
                  hit_ff    <= 1'b0;
                  state_ff  <= (fill_ff == '0) ? ST_FINISH : ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (key_match) begin
                  hit_ff      <= 1'b1;
                  hit_lane_ff <= tbl_rd_lane;
                  state_ff    <= ST_FINISH;
               end else if (scan_last) begin
                  state_ff <= ST_FINISH;
               end else begin
                  rd_idx_ff <= rd_idx_ff + AW'(1);
               end
            end
            ST_FINISH: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
                  if (hit_ff) begin
                     rsp_lane_ff  <= LANE_W'(hit_lane_ff);
                     rsp_known_ff <= 1'b1;
                     rsp_full_ff  <= 1'b0;
                  end else begin
                     rsp_lane_ff  <= LANE_W'(tok_lane);
                     rsp_known_ff <= 1'b0;
                     rsp_full_ff  <= !table_has_room;
                     token_ff     <= token_in;
                     if (table_has_room) begin
                        fill_ff <= fill_ff + (AW + 1)'(1);
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
